[hdl/mcrq_pkg.sv]
// Shared types and constants for the multi-channel rise qualifier.
// No dependencies; used by the top level and mcrq_update.
`default_nettype none

package mcrq_pkg;

    localparam int unsigned CHANNEL_W        = 6;
    localparam int unsigned TIME_W           = 32;
    localparam int unsigned DEBOUNCE_W       = 16;
    localparam int unsigned CHANNELS_DEFAULT = 64;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(100);

    // One channel entry as held in the state memory.
    typedef struct packed {
        logic              level;
        logic              armed;
        logic [TIME_W-1:0] rise_time;
    } entry_t;

    // Decision for one sample: write-back and event.
    typedef struct packed {
        logic   wr_en;
        entry_t entry;
        logic   ev_valid;
        logic   ev_level;
    } upd_t;

endpackage

`default_nettype wire

[hdl/multi_channel_rise_qualifier.sv]
// Multi-channel rise qualifier: top level.
// Depends on mcrq_pkg, mcrq_ram and mcrq_update.
`default_nettype none

// Takes one sample item per clock (channel, level, millisecond time) and
// reports a fall at once and a rise only once the channel has stayed high
// for debounce_ms milliseconds, measured modulo 2^32. An event passes
// through the sample stage and the output register. The rate is set by
// the single read-modify-write of the per-channel entry, read from a RAM
// with registered read data at acceptance, updated in the sample stage
// and written back as that stage advances; a bypass register covers a
// sample that follows one of the same channel. Entries read as zero until
// first written (a valid flag per channel), so no clearing pass follows
// reset. Samples for channels at or above CHANNELS are taken and dropped
// without effect. The output register lets a new item in while an event
// waits; only a stalled event halts input.
// Write debounce_ms through the cfg port only while the block is idle.

module multi_channel_rise_qualifier #(
    parameter int unsigned CHANNELS = mcrq_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // sample items
    input  wire logic                            sample_valid,
    output logic                                 sample_stall,
    input  wire logic [mcrq_pkg::CHANNEL_W-1:0]  channel,
    input  wire logic                            level,
    input  wire logic [mcrq_pkg::TIME_W-1:0]     now_ms,
    // event items
    output logic                                 event_valid,
    input  wire logic                            event_stall,
    output logic      [mcrq_pkg::CHANNEL_W-1:0]  event_channel,
    output logic                                 event_level,
    // debounce register write
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mcrq_pkg::DEBOUNCE_W-1:0] cfg_data
);

    import mcrq_pkg::*;

    localparam int unsigned ADDR_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned ENTRY_W = $bits(entry_t);

    // Configuration register
    logic [DEBOUNCE_W-1:0] debounce_reg;

    // Sample pipeline stage: RAM read in flight
    logic                  s1_valid_reg;
    logic [CHANNEL_W-1:0]  s1_channel_reg;
    logic                  s1_level_reg;
    logic [TIME_W-1:0]     s1_now_reg;
    logic                  s1_in_range_reg;
    logic [ADDR_W-1:0]     s1_addr;

    // Output register
    logic                  out_valid_reg;
    logic [CHANNEL_W-1:0]  out_channel_reg;
    logic                  out_level_reg;

    // Write bypass and per-channel valid flags
    logic                  byp_valid_reg;
    logic [ADDR_W-1:0]     byp_addr_reg;
    entry_t                byp_data_reg;
    logic [CHANNELS-1:0]   filled_reg;

    logic                  advance;
    logic                  accept;
    logic                  in_range;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ENTRY_W-1:0]    rd_data;
    entry_t                cur;
    upd_t                  upd;
    logic                  wr_en;

    // Halt only while a finished event is stuck in the output register.
    assign advance      = !out_valid_reg || !event_stall;
    assign sample_stall = !advance;
    assign accept       = sample_valid && advance;

    assign in_range = ({1'b0, channel} < (CHANNEL_W + 1)'(CHANNELS))
                      || (CHANNELS > (1 << CHANNEL_W));
    assign rd_addr  = ADDR_W'(channel);
    assign s1_addr  = ADDR_W'(s1_channel_reg);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            debounce_reg <= cfg_data;
        end
    end

    mcrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (upd.entry),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pick the freshest copy of the entry: the write that coincided with
    // the read, else the RAM, else the reset value for an unwritten channel.
    always_comb
    begin
        if (byp_valid_reg && (byp_addr_reg == s1_addr))
        begin
            cur = byp_data_reg;
        end
        else if (s1_in_range_reg && filled_reg[s1_addr])
        begin
            cur = entry_t'(rd_data);
        end
        else
        begin
            cur = '0;
        end
    end

    mcrq_update u_update (
        .in_range    (s1_in_range_reg),
        .level       (s1_level_reg),
        .now_ms      (s1_now_reg),
        .debounce_ms (debounce_reg),
        .cur         (cur),
        .upd         (upd)
    );

    assign wr_en = advance && s1_valid_reg && upd.wr_en;

    // Advance the sample stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_channel_reg  <= channel;
            s1_level_reg    <= level;
            s1_now_reg      <= now_ms;
            s1_in_range_reg <= in_range;
        end
    end

    // Record each write for the bypass and mark the channel as written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
            filled_reg    <= '0;
        end
        else if (wr_en)
        begin
            byp_valid_reg        <= 1'b1;
            filled_reg[s1_addr]  <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_addr_reg <= s1_addr;
            byp_data_reg <= upd.entry;
        end
    end

    // Output register: load a new event, or drop the one just taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg && upd.ev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && upd.ev_valid)
        begin
            out_channel_reg <= s1_channel_reg;
            out_level_reg   <= upd.ev_level;
        end
    end

    assign event_valid   = out_valid_reg;
    assign event_channel = out_channel_reg;
    assign event_level   = out_level_reg;

    // An event never names a channel outside the store.
    a_event_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        event_valid |-> (int'(event_channel) < CHANNELS))
        else $error("event for a channel beyond CHANNELS");

    // Only in-range samples touch the store.
    a_write_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> s1_in_range_reg)
        else $error("state write for an out-of-range sample");

    // A qualified rise needs an armed, high entry.
    a_rise_armed : assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && upd.ev_valid && upd.ev_level) |-> (cur.armed && cur.level))
        else $error("rise reported for a disarmed channel");

    // Every write lands in the bypass for the next read.
    a_bypass_follows : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (byp_valid_reg && (byp_addr_reg == $past(s1_addr))))
        else $error("bypass register missed a write");

endmodule

`default_nettype wire

[hdl/mcrq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module mcrq_ram #(
    parameter  int unsigned WIDTH = 8,
    parameter  int unsigned DEPTH = 64,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/mcrq_update.sv]
// Per-sample decision logic: next channel entry and the event it raises.
// Depends on mcrq_pkg.
`default_nettype none

module mcrq_update (
    input  wire logic                            in_range,
    input  wire logic                            level,
    input  wire logic [mcrq_pkg::TIME_W-1:0]     now_ms,
    input  wire logic [mcrq_pkg::DEBOUNCE_W-1:0] debounce_ms,
    input  wire mcrq_pkg::entry_t                cur,
    output mcrq_pkg::upd_t                       upd
);

    import mcrq_pkg::*;

    logic [TIME_W-1:0] elapsed;
    logic              qualified;

    // Wrap-around elapsed time since the recorded rise.
    assign elapsed   = now_ms - cur.rise_time;
    assign qualified = (elapsed >= TIME_W'(debounce_ms));

    always_comb
    begin
        upd          = '0;
        upd.entry    = cur;
        upd.wr_en    = in_range;
        if (in_range)
        begin
            if (level != cur.level)
            begin
                upd.entry.level = level;
                if (!level)
                begin
                    // drop the arm and report the fall at once
                    upd.entry.armed = 1'b0;
                    upd.ev_valid    = 1'b1;
                    upd.ev_level    = 1'b0;
                end
                else
                begin
                    upd.entry.armed     = 1'b1;
                    upd.entry.rise_time = now_ms;
                end
            end
            else if (level && cur.armed && qualified)
            begin
                upd.entry.armed = 1'b0;
                upd.ev_valid    = 1'b1;
                upd.ev_level    = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
